// File: hw/rtl/ets_pkg.sv
// Shared types, token kind codes, scan mode codes and keyword tables
// for the expression token scanner. No dependencies.
package ets_pkg;

    localparam int unsigned MAX_TEXT_LENGTH = 65536;
    // Highest position the scanner counts to before it saturates.
    localparam logic [15:0] POS_MAX = (MAX_TEXT_LENGTH - 1 > 65535) ? 16'hFFFF
                                      : 16'(MAX_TEXT_LENGTH - 1);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_NUM   = 3'd1;
    localparam logic [2:0] MODE_IDENT = 3'd2;
    localparam logic [2:0] MODE_STAR  = 3'd3;
    localparam logic [2:0] MODE_PLUS  = 3'd4;

    localparam logic [3:0] K_NUM     = 4'd0;
    localparam logic [3:0] K_IDENT   = 4'd1;
    localparam logic [3:0] K_PRINT   = 4'd2;
    localparam logic [3:0] K_SQRT    = 4'd3;
    localparam logic [3:0] K_PLUS    = 4'd4;
    localparam logic [3:0] K_MINUS   = 4'd5;
    localparam logic [3:0] K_MUL     = 4'd6;
    localparam logic [3:0] K_DIV     = 4'd7;
    localparam logic [3:0] K_POW     = 4'd8;
    localparam logic [3:0] K_PLUS_EQ = 4'd9;
    localparam logic [3:0] K_LPAREN  = 4'd10;
    localparam logic [3:0] K_RPAREN  = 4'd11;
    localparam logic [3:0] K_SEMI    = 4'd12;
    localparam logic [3:0] K_ASSIGN  = 4'd13;
    localparam logic [3:0] K_ERROR   = 4'd14;
    localparam logic [3:0] K_END     = 4'd15;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  bad;
        logic        last;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t tok;
    } token_slot_t;

    // Up to two tokens per byte: the pending one closed, then the byte's own.
    typedef struct packed {
        token_slot_t closed;
        token_slot_t fresh;
    } lex_out_t;

    function automatic logic [7:0] kw_print_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "p";
            3'd1:    c = "r";
            3'd2:    c = "i";
            3'd3:    c = "n";
            3'd4:    c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_sqrt_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "s";
            2'd1:    c = "q";
            2'd2:    c = "r";
            default: c = "t";
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ets_lexer.sv
// Scan state and per-byte token decision of the expression token scanner.
// Depends on ets_pkg.
module ets_lexer
    import ets_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] byte_in,
    output lex_out_t   lex_out
);

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] pos_reg, pos_next;
    logic        print_ok_reg, print_ok_next;
    logic        sqrt_ok_reg, sqrt_ok_next;

    logic [15:0] cur_len;
    logic        is_digit, is_alpha, rescan;
    logic [3:0]  one_kind;

    assign cur_len  = (pos_reg >= start_reg) ? (pos_reg - start_reg) : 16'd0;
    assign is_digit = byte_in inside {["0":"9"]};
    assign is_alpha = byte_in inside {["a":"z"], ["A":"Z"]};

    always_comb begin
        case (byte_in)
            "-":     one_kind = K_MINUS;
            "/":     one_kind = K_DIV;
            "(":     one_kind = K_LPAREN;
            ")":     one_kind = K_RPAREN;
            ";":     one_kind = K_SEMI;
            "=":     one_kind = K_ASSIGN;
            default: one_kind = K_ERROR;
        endcase
    end

    always_comb begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        pos_next      = pos_reg;
        print_ok_next = print_ok_reg;
        sqrt_ok_next  = sqrt_ok_reg;
        rescan        = 1'b1;
        lex_out       = '0;

        // Close or extend the pending token.
        case (mode_reg)
            MODE_NUM: begin
                if (is_digit) begin
                    rescan = 1'b0;
                end else begin
                    lex_out.closed.valid      = 1'b1;
                    lex_out.closed.tok.kind   = K_NUM;
                    lex_out.closed.tok.start  = start_reg;
                    lex_out.closed.tok.length = cur_len;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDENT: begin
                if (is_digit || is_alpha) begin
                    print_ok_next = print_ok_reg && (cur_len < 16'd5)
                                    && (byte_in == kw_print_char(cur_len[2:0]));
                    sqrt_ok_next  = sqrt_ok_reg && (cur_len < 16'd4)
                                    && (byte_in == kw_sqrt_char(cur_len[1:0]));
                    rescan = 1'b0;
                end else begin
                    lex_out.closed.valid      = 1'b1;
                    lex_out.closed.tok.start  = start_reg;
                    lex_out.closed.tok.length = cur_len;
                    if (print_ok_reg && cur_len == 16'd5) begin
                        lex_out.closed.tok.kind = K_PRINT;
                    end else if (sqrt_ok_reg && cur_len == 16'd4) begin
                        lex_out.closed.tok.kind = K_SQRT;
                    end else begin
                        lex_out.closed.tok.kind = K_IDENT;
                    end
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STAR: begin
                lex_out.closed.valid     = 1'b1;
                lex_out.closed.tok.start = start_reg;
                if (byte_in == "*") begin
                    lex_out.closed.tok.kind   = K_POW;
                    lex_out.closed.tok.length = 16'd2;
                    rescan = 1'b0;
                end else begin
                    lex_out.closed.tok.kind   = K_MUL;
                    lex_out.closed.tok.length = 16'd1;
                end
                mode_next = MODE_IDLE;
            end
            MODE_PLUS: begin
                lex_out.closed.valid     = 1'b1;
                lex_out.closed.tok.start = start_reg;
                if (byte_in == "=") begin
                    lex_out.closed.tok.kind   = K_PLUS_EQ;
                    lex_out.closed.tok.length = 16'd2;
                    rescan = 1'b0;
                end else begin
                    lex_out.closed.tok.kind   = K_PLUS;
                    lex_out.closed.tok.length = 16'd1;
                end
                mode_next = MODE_IDLE;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Scan the byte afresh from idle.
        if (rescan && byte_in == 8'h00) begin
            lex_out.fresh.valid      = 1'b1;
            lex_out.fresh.tok.kind   = K_END;
            lex_out.fresh.tok.start  = pos_reg;
            lex_out.fresh.tok.length = 16'd0;
            mode_next     = MODE_IDLE;
            start_next    = '0;
            print_ok_next = 1'b0;
            sqrt_ok_next  = 1'b0;
        end else begin
            if (rescan) begin
                if (is_digit) begin
                    mode_next  = MODE_NUM;
                    start_next = pos_reg;
                end else if (is_alpha) begin
                    mode_next     = MODE_IDENT;
                    start_next    = pos_reg;
                    print_ok_next = (byte_in == "p");
                    sqrt_ok_next  = (byte_in == "s");
                end else if (byte_in == "*") begin
                    mode_next  = MODE_STAR;
                    start_next = pos_reg;
                end else if (byte_in == "+") begin
                    mode_next  = MODE_PLUS;
                    start_next = pos_reg;
                end else if (byte_in != " ") begin
                    lex_out.fresh.valid      = 1'b1;
                    lex_out.fresh.tok.kind   = one_kind;
                    lex_out.fresh.tok.start  = pos_reg;
                    lex_out.fresh.tok.length = 16'd1;
                    lex_out.fresh.tok.bad    = (one_kind == K_ERROR) ? byte_in : 8'h00;
                end
            end
            if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 16'd1;
            end
        end

        // The end of text restarts the position count.
        if (rescan && byte_in == 8'h00) begin
            pos_next = '0;
        end

        lex_out.closed.tok.last = !lex_out.fresh.valid;
        lex_out.fresh.tok.last  = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            start_reg    <= '0;
            pos_reg      <= '0;
            print_ok_reg <= 1'b0;
            sqrt_ok_reg  <= 1'b0;
        end else if (step) begin
            mode_reg     <= mode_next;
            start_reg    <= start_next;
            pos_reg      <= pos_next;
            print_ok_reg <= print_ok_next;
            sqrt_ok_reg  <= sqrt_ok_next;
        end
    end

endmodule

// File: hw/rtl/ets_token_fifo.sv
// Four-entry result queue that takes up to two tokens a cycle.
// Depends on ets_pkg.
module ets_token_fifo
    import ets_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  lex_out_t push_data,
    output logic     room_for_two,
    output logic     out_valid,
    input  logic     out_ready,
    output token_t   out_tok
);

    token_t      mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  push_n;
    logic        pop;
    token_t      first_tok;

    assign push_n = push ? ({1'b0, push_data.closed.valid} + {1'b0, push_data.fresh.valid})
                         : 2'd0;
    assign first_tok    = push_data.closed.valid ? push_data.closed.tok : push_data.fresh.tok;
    assign pop          = out_valid && out_ready;
    assign room_for_two = (count_reg <= 3'd2);
    assign out_valid    = (count_reg != 3'd0);
    assign out_tok      = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= first_tok;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= push_data.fresh.tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/expression_token_scanner.sv
// Expression token scanner: streaming lexer for a small arithmetic language.
// Source bytes come in on the s_ channel, one byte per word; tokens leave on the
// m_ channel as kind, start position and length, one token per word. A byte that
// closes a pending number, identifier or operator and is then its own token
// gives two words; m_last_of_run marks the final word of each byte. Byte
// zero closes any pending token, then sends END and restarts the position at 0.
// An accepted byte is held in the input register and scanned from there; its
// tokens are written into the token queue and offered from that queue.
// Throughput: one byte per cycle while each byte gives at most one token and the
// receiver keeps up; the four-word token queue absorbs the extra word of a byte
// that gives two tokens.
// Stall: when the receiver drops m_ready the queue fills; the scanner holds its
// input byte once fewer than two queue entries are free, and s_ready then falls.
// s_ready depends only on registered state, never on m_ready in the same cycle.
// Reset (aresetn low, synchronous): drop all queued tokens and the held byte,
// return the scanner to idle with position and token start at zero.
// Depends on ets_pkg, ets_lexer and ets_token_fifo.
module expression_token_scanner
    import ets_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [15:0] m_token_start,
    output logic [15:0] m_token_length,
    output logic [7:0]  m_bad_byte,
    output logic        m_last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room_for_two;
    logic       advance;
    lex_out_t   lex_out;
    token_t     out_tok;

    // Scan the held byte only when the queue can take both of its tokens.
    assign advance = in_valid_reg && room_for_two;
    assign s_ready = !in_valid_reg || advance;

    // Input register: hold the byte until the scanner takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_source_byte;
        end
    end

    ets_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .byte_in (in_byte_reg),
        .lex_out (lex_out)
    );

    ets_token_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (advance),
        .push_data    (lex_out),
        .room_for_two (room_for_two),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_tok      (out_tok)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_token_start  = out_tok.start;
    assign m_token_length = out_tok.length;
    assign m_bad_byte     = out_tok.bad;
    assign m_last_of_run  = out_tok.last;

endmodule
